### src/wfba_pkg.sv
// shared types and constants of the worst-fit block allocator
package wfba_pkg;

   // fixed field widths of the channel words and the csr
   localparam int IN_INDEX_WIDTH = 4;
   localparam int IN_SIZE_WIDTH  = 16;
   localparam int COUNT_WIDTH    = 5;

   // mode codes of the request word
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;
      logic load;
      logic scan_step;
      logic update;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_load;
      logic limit_zero;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

### src/wfba_if.sv
// handshake interfaces of the request and response channels

interface wfba_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic [wfba_pkg::IN_INDEX_WIDTH-1:0]  block_index;
   logic [wfba_pkg::IN_SIZE_WIDTH-1:0]   size_value;

   modport source (output valid, output mode, output block_index, output size_value,
                   input ready);
   modport sink   (input valid, input mode, input block_index, input size_value,
                   output ready);
endinterface

interface wfba_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 granted;
   logic [wfba_pkg::IN_INDEX_WIDTH-1:0]  chosen_block;
   logic [wfba_pkg::IN_SIZE_WIDTH-1:0]   remaining;

   modport source (output valid, output granted, output chosen_block, output remaining,
                   input ready);
   modport sink   (input valid, input granted, input chosen_block, input remaining,
                   output ready);
endinterface

### src/worst_fit_block_allocator_unit.sv
// Worst-fit block allocator. Keeps the remaining free size of BLOCK_DEPTH memory
// blocks in a simple dual-port block memory (valid bits make every block read as zero
// after reset). A load word (mode 0) sets one block's size and answers with the
// block and its saturated size; an index beyond the memory is answered as not
// granted. A request word (mode 1) reads the first block_count blocks one per
// cycle through the memory read port, keeps the largest remaining size strictly
// above the request (ties to the highest index), subtracts the request and
// answers with the block and its new remaining size, or not granted with zeros.
// One word is worked on at a time: a load passes the start and result states, a
// request the start, scan, drain, update and result states (start, update and
// result when n is zero), n being block_count clamped to BLOCK_DEPTH, the scan
// running sequentially over the memory read port.
// The response sits in an output register, so the block takes the next request
// word while a response still waits to be taken. The user must write block_count
// through the csr port only while idle; the block itself does not enforce this.
module worst_fit_block_allocator_unit #(
   parameter int BLOCK_DEPTH = 16,
   parameter int SIZE_WIDTH  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [wfba_pkg::COUNT_WIDTH-1:0] csr_write_data,
   wfba_req_if.sink                         req_chan,
   wfba_rsp_if.source                       rsp_chan
);

   wfba_pkg::cmd_type    cmd;
   wfba_pkg::status_type status;

   // sequencing of each word
   wfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, scan and response
   wfba_datapath #(
      .BLOCK_DEPTH (BLOCK_DEPTH),
      .SIZE_WIDTH  (SIZE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_mode          (req_chan.mode),
      .in_block_index   (req_chan.block_index),
      .in_size_value    (req_chan.size_value),
      .out_ready        (rsp_chan.ready),
      .out_valid        (rsp_chan.valid),
      .out_granted      (rsp_chan.granted),
      .out_chosen_block (rsp_chan.chosen_block),
      .out_remaining    (rsp_chan.remaining),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

### src/wfba_ctrl.sv
// controller state machine of the worst-fit block allocator
module wfba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wfba_pkg::status_type status,
   output wfba_pkg::cmd_type    cmd
);

   wfba_pkg::state_type state_ff;
   wfba_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wfba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = wfba_pkg::ST_START;
            end
         end
         wfba_pkg::ST_START: begin
            if (status.is_load) begin
               cmd.load = 1'b1;
               state_in = wfba_pkg::ST_RESULT;
            end else if (status.limit_zero) begin
               state_in = wfba_pkg::ST_UPDATE;
            end else begin
               state_in = wfba_pkg::ST_SCAN;
            end
         end
         wfba_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = wfba_pkg::ST_DRAIN;
            end
         end
         // last read word is compared here
         wfba_pkg::ST_DRAIN: begin
            state_in = wfba_pkg::ST_UPDATE;
         end
         wfba_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = wfba_pkg::ST_RESULT;
         end
         wfba_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = wfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/wfba_datapath.sv
// datapath: block memory, scan compare, result and output registers
module wfba_datapath #(
   parameter int BLOCK_DEPTH = 16,
   parameter int SIZE_WIDTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wfba_pkg::COUNT_WIDTH-1:0]    csr_write_data,
   input  logic                                in_mode,
   input  logic [wfba_pkg::IN_INDEX_WIDTH-1:0] in_block_index,
   input  logic [wfba_pkg::IN_SIZE_WIDTH-1:0]  in_size_value,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic                                out_granted,
   output logic [wfba_pkg::IN_INDEX_WIDTH-1:0] out_chosen_block,
   output logic [wfba_pkg::IN_SIZE_WIDTH-1:0]  out_remaining,
   input  wfba_pkg::cmd_type                   cmd,
   output wfba_pkg::status_type                status
);

   localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int CNT_W = $clog2(BLOCK_DEPTH + 1);
   localparam int CW    = (SIZE_WIDTH > wfba_pkg::IN_SIZE_WIDTH) ? SIZE_WIDTH
                                                                 : wfba_pkg::IN_SIZE_WIDTH;
   localparam logic [CW-1:0] SIZE_MAX = CW'({SIZE_WIDTH{1'b1}});

   // block memory with per-entry valid bits
   logic [SIZE_WIDTH-1:0]  mem [BLOCK_DEPTH];
   logic [BLOCK_DEPTH-1:0] valid_ff;

   logic [wfba_pkg::COUNT_WIDTH-1:0]    count_ff;
   logic                                mode_ff;
   logic [wfba_pkg::IN_INDEX_WIDTH-1:0] idx_ff;
   logic [wfba_pkg::IN_SIZE_WIDTH-1:0]  size_ff;
   logic [CNT_W-1:0]                    limit_ff;
   logic [CNT_W-1:0]                    limit_in;
   logic [CNT_W-1:0]                    addr_ff;
   logic [SIZE_WIDTH-1:0]               rd_data_ff;
   logic [IDX_W-1:0]                    rd_idx_ff;
   logic                                rd_valid_ff;
   logic [SIZE_WIDTH-1:0]               best_ff;
   logic [IDX_W-1:0]                    best_idx_ff;
   logic                                found_ff;
   logic                                res_granted_ff;
   logic [wfba_pkg::IN_INDEX_WIDTH-1:0] res_chosen_ff;
   logic [wfba_pkg::IN_SIZE_WIDTH-1:0]  res_rem_ff;
   logic                                rsp_valid_ff;
   logic                                rsp_granted_ff;
   logic [wfba_pkg::IN_INDEX_WIDTH-1:0] rsp_chosen_ff;
   logic [wfba_pkg::IN_SIZE_WIDTH-1:0]  rsp_rem_ff;

   logic                  take;
   logic                  load_hit;
   logic [SIZE_WIDTH-1:0] load_val;
   logic [SIZE_WIDTH-1:0] alloc_val;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [SIZE_WIDTH-1:0] mem_wdata;

   // block count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // blocks in use, clamped to the memory depth
   always_comb begin
      if (32'(count_ff) > BLOCK_DEPTH) begin
         limit_in = CNT_W'(BLOCK_DEPTH);
      end else begin
         limit_in = CNT_W'(count_ff);
      end
   end

   // compare of the word read in the previous cycle
   assign take = rd_valid_ff && (CW'(size_ff) < CW'(rd_data_ff))
                 && (!found_ff || (rd_data_ff >= best_ff));

   // load value saturates, allocation subtracts from the best block
   assign load_hit  = 32'(idx_ff) < BLOCK_DEPTH;
   assign load_val  = (CW'(size_ff) > SIZE_MAX) ? {SIZE_WIDTH{1'b1}}
                                                 : SIZE_WIDTH'(size_ff);
   assign alloc_val = SIZE_WIDTH'(CW'(best_ff) - CW'(size_ff));

   // memory write port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = alloc_val;
      if (cmd.load) begin
         mem_we    = load_hit;
         mem_waddr = IDX_W'(idx_ff);
         mem_wdata = load_val;
      end else if (cmd.update) begin
         mem_we    = found_ff;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= valid_ff[addr_ff[IDX_W-1:0]] ? mem[addr_ff[IDX_W-1:0]] : '0;
         rd_idx_ff  <= addr_ff[IDX_W-1:0];
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_waddr] <= 1'b1;
      end
   end

   // input word latch and scan address
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= in_mode;
         idx_ff   <= in_block_index;
         size_ff  <= in_size_value;
         limit_ff <= limit_in;
      end
      if (cmd.latch) begin
         addr_ff <= '0;
      end else if (cmd.scan_step) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   // running best of the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
         if (cmd.latch) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= rd_data_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // result word of the current item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_granted_ff <= load_hit;
         res_chosen_ff  <= load_hit ? idx_ff : '0;
         res_rem_ff     <= load_hit ? wfba_pkg::IN_SIZE_WIDTH'(load_val) : '0;
      end else if (cmd.update) begin
         res_granted_ff <= found_ff;
         res_chosen_ff  <= found_ff ? wfba_pkg::IN_INDEX_WIDTH'(best_idx_ff) : '0;
         res_rem_ff     <= found_ff ? wfba_pkg::IN_SIZE_WIDTH'(alloc_val) : '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_chosen_ff  <= res_chosen_ff;
         rsp_rem_ff     <= res_rem_ff;
      end
   end

   assign out_valid        = rsp_valid_ff;
   assign out_granted      = rsp_granted_ff;
   assign out_chosen_block = rsp_chosen_ff;
   assign out_remaining    = rsp_rem_ff;

   // status to the controller
   assign status.is_load    = (mode_ff == wfba_pkg::MODE_LOAD);
   assign status.limit_zero = (limit_ff == '0);
   assign status.scan_last  = (addr_ff == CNT_W'(limit_ff - 1'b1));
   assign status.out_free   = !rsp_valid_ff || out_ready;

endmodule
